[rtl/bcsp_pkg.sv]
// Shared types and codes for the beacon channel scan parser.
// No dependencies; imported by beacon_channel_scan_parser_core.
`default_nettype none

package bcsp_pkg;

  // Input word kinds (in_tuser)
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;

  // Result kinds (out_tuser)
  localparam logic KIND_SSID    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_INACTIVE = 2'd0;
  localparam logic [1:0] VERDICT_PRIMARY  = 2'd1;
  localparam logic [1:0] VERDICT_USED_BY  = 2'd2;
  localparam logic [1:0] VERDICT_UNKNOWN  = 2'd3;

  // Register indexes on the config port
  localparam logic [1:0] REG_SCAN_CHANNEL    = 2'd0;
  localparam logic [1:0] REG_NONBEACON_LIMIT = 2'd1;
  localparam logic [1:0] REG_ELEMENT_START   = 2'd2;

  // Element tags of interest
  localparam logic [7:0] TAG_SSID = 8'd0;
  localparam logic [7:0] TAG_DS   = 8'd3;

  // Frame control byte: type bits [3:2] = 0, subtype bits [7:4] = 8
  localparam logic [7:0] FC_MASK   = 8'hfc;
  localparam logic [7:0] FC_BEACON = 8'h80;

  localparam logic [7:0] FRAME_COUNT_MAX = 8'hff;

  // Reset values of the registers
  localparam logic [3:0] RST_SCAN_CHANNEL    = 4'd1;
  localparam logic [7:0] RST_NONBEACON_LIMIT = 8'd25;
  localparam logic [7:0] RST_ELEMENT_START   = 8'd36;

  // One result word as held in the output queue
  typedef struct packed {
    logic       kind;
    logic [7:0] ssid_char;
    logic [1:0] verdict;
    logic [7:0] beacon_channel;
    logic       channel_found;
    logic       last;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/beacon_channel_scan_parser_core.sv]
// Beacon channel scan parser: frame byte walker, verdict logic, result queue.
// Depends on bcsp_pkg.
`default_nettype none

// Usage
//   in_*  : one word per frame byte, listen timeout or start-of-scan command.
//           in_tuser = cmd, in_tdata = received byte, in_tlast = last byte
//           of the frame.
//   out_* : SSID bytes (out_tuser = 0) and scan verdicts (out_tuser = 1).
//           out_tlast marks the last result caused by one input word.
//   cfg_* : register writes, only while the block is idle.
// Timing
//   Each input word is fully handled in the cycle it is accepted; its
//   results are registered into a 4-entry output queue that drives out_*.
//   One input word per cycle is sustained while in_tready is high; a
//   frame-end byte can produce two results (SSID byte plus verdict),
//   which the queue absorbs and drains one per cycle while out_tready is high.
//   in_tready drops while fewer than two queue slots are free, so a stalled
//   receiver backs up to the input once three results are queued.
// Reset
//   rst_n low clears parse state, frame count, scan-done flag and the
//   queue, and loads registers with channel 1, limit 25, elements at 36.
//   After a verdict nothing more is reported until a start command.
module beacon_channel_scan_parser_core
  import bcsp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 4096,
  parameter int SSID_MAX        = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata : [7:0] data_byte
  input  wire logic [7:0]  in_tdata,
  // in_tuser : [1:0] cmd
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata : [7:0] ssid_char, [9:8] verdict, [17:10] beacon_channel,
  //             [18] channel_found, [23:19] zero
  output logic [23:0]      out_tdata,
  // out_tuser : [0] kind
  output logic             out_tuser,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int PosW   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CmpW   = (PosW > 8) ? PosW : 8;
  localparam int SsidW  = $clog2(SSID_MAX + 1);
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // Config registers
  logic [3:0] scan_channel_r;
  logic [7:0] nonbeacon_limit_r;
  logic [7:0] element_start_r;

  // Parse state
  logic [PosW-1:0]  byte_pos_r,    byte_pos_nxt;
  logic             beacon_r,      beacon_nxt;
  phase_t           phase_r,       phase_nxt;
  logic [7:0]       tag_r,         tag_nxt;
  logic [7:0]       remain_r,      remain_nxt;
  logic [SsidW-1:0] ssid_cnt_r,    ssid_cnt_nxt;
  logic             ssid_ended_r,  ssid_ended_nxt;
  logic [7:0]       found_ch_r,    found_ch_nxt;
  logic             found_r,       found_nxt;
  logic [7:0]       frame_cnt_r,   frame_cnt_nxt;
  logic             scan_done_r,   scan_done_nxt;

  // Output queue
  out_word_t        q_mem_r [QDepth];
  logic [QPtrW-1:0] q_wp_r, q_rp_r;
  logic [QCntW-1:0] q_cnt_r;

  logic       in_fire, out_fire;
  logic       ssid_emit, verdict_emit;
  logic [1:0] verdict_code;
  logic [7:0] verdict_ch;
  logic       verdict_found;
  logic [7:0] remain_dec;
  logic       walk_en;
  out_word_t  ssid_word, verdict_word, wr0_word;
  logic       wr0, wr1;
  logic [QPtrW-1:0] q_wp1;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_tready = (q_cnt_r <= QCntW'(QDepth - 2));

  // Per-word parse step
  always_comb begin
    byte_pos_nxt   = byte_pos_r;
    beacon_nxt     = beacon_r;
    phase_nxt      = phase_r;
    tag_nxt        = tag_r;
    remain_nxt     = remain_r;
    ssid_cnt_nxt   = ssid_cnt_r;
    ssid_ended_nxt = ssid_ended_r;
    found_ch_nxt   = found_ch_r;
    found_nxt      = found_r;
    frame_cnt_nxt  = frame_cnt_r;
    scan_done_nxt  = scan_done_r;
    ssid_emit      = 1'b0;
    verdict_emit   = 1'b0;
    verdict_code   = VERDICT_INACTIVE;
    verdict_ch     = 8'd0;
    verdict_found  = 1'b0;
    remain_dec     = remain_r - 8'd1;
    walk_en        = 1'b0;

    case (in_tuser)
      CMD_START: begin
        byte_pos_nxt   = '0;
        beacon_nxt     = 1'b0;
        phase_nxt      = PH_TAG;
        tag_nxt        = 8'd0;
        remain_nxt     = 8'd0;
        ssid_cnt_nxt   = '0;
        ssid_ended_nxt = 1'b0;
        found_ch_nxt   = 8'd0;
        found_nxt      = 1'b0;
        frame_cnt_nxt  = 8'd0;
        scan_done_nxt  = 1'b0;
      end
      CMD_TIMEOUT: begin
        if (!scan_done_r) begin
          byte_pos_nxt   = '0;
          beacon_nxt     = 1'b0;
          phase_nxt      = PH_TAG;
          tag_nxt        = 8'd0;
          remain_nxt     = 8'd0;
          ssid_cnt_nxt   = '0;
          ssid_ended_nxt = 1'b0;
          found_ch_nxt   = 8'd0;
          found_nxt      = 1'b0;
          scan_done_nxt  = 1'b1;
          verdict_emit   = 1'b1;
          verdict_code   = VERDICT_INACTIVE;
        end
      end
      CMD_BYTE: begin
        if (!scan_done_r) begin
          if (byte_pos_r < PosW'(MAX_FRAME_BYTES)) begin
            if (byte_pos_r == '0)
              beacon_nxt = ((in_tdata & FC_MASK) == FC_BEACON);
            walk_en = beacon_nxt && !found_r &&
                      (CmpW'(byte_pos_r) >= CmpW'(element_start_r));
            byte_pos_nxt = byte_pos_r + PosW'(1);
          end

          if (walk_en) begin
            case (phase_r)
              PH_TAG: begin
                tag_nxt   = in_tdata;
                phase_nxt = PH_LEN;
              end
              PH_LEN: begin
                remain_nxt = in_tdata;
                phase_nxt  = (in_tdata == 8'd0) ? PH_TAG : PH_BODY;
              end
              default: begin
                if (tag_r == TAG_SSID) begin
                  if (!ssid_ended_r) begin
                    if (in_tdata == 8'd0) begin
                      ssid_ended_nxt = 1'b1;
                    end else if (ssid_cnt_r < SsidW'(SSID_MAX)) begin
                      ssid_emit    = 1'b1;
                      ssid_cnt_nxt = ssid_cnt_r + SsidW'(1);
                    end
                  end
                end else if (tag_r == TAG_DS) begin
                  found_ch_nxt = in_tdata;
                  found_nxt    = 1'b1;
                end
                remain_nxt = remain_dec;
                if (remain_dec == 8'd0) begin
                  if (tag_r == TAG_SSID)
                    ssid_ended_nxt = 1'b1;
                  phase_nxt = PH_TAG;
                end
              end
            endcase
          end

          if (in_tlast) begin
            if (beacon_nxt) begin
              verdict_emit  = 1'b1;
              verdict_code  = (found_nxt && (found_ch_nxt == {4'd0, scan_channel_r})) ?
                              VERDICT_PRIMARY : VERDICT_USED_BY;
              verdict_ch    = found_nxt ? found_ch_nxt : 8'd0;
              verdict_found = found_nxt;
              scan_done_nxt = 1'b1;
            end else begin
              if (frame_cnt_r < FRAME_COUNT_MAX)
                frame_cnt_nxt = frame_cnt_r + 8'd1;
              if (frame_cnt_nxt > nonbeacon_limit_r) begin
                verdict_emit  = 1'b1;
                verdict_code  = VERDICT_UNKNOWN;
                scan_done_nxt = 1'b1;
              end
            end
            byte_pos_nxt   = '0;
            beacon_nxt     = 1'b0;
            phase_nxt      = PH_TAG;
            tag_nxt        = 8'd0;
            remain_nxt     = 8'd0;
            ssid_cnt_nxt   = '0;
            ssid_ended_nxt = 1'b0;
            found_ch_nxt   = 8'd0;
            found_nxt      = 1'b0;
          end
        end
      end
      default: ;  // unused command: no effect
    endcase
  end

  // Result words; the later one carries last
  always_comb begin
    ssid_word.kind           = KIND_SSID;
    ssid_word.ssid_char      = in_tdata;
    ssid_word.verdict        = VERDICT_INACTIVE;
    ssid_word.beacon_channel = 8'd0;
    ssid_word.channel_found  = 1'b0;
    ssid_word.last           = !verdict_emit;

    verdict_word.kind           = KIND_VERDICT;
    verdict_word.ssid_char      = 8'd0;
    verdict_word.verdict        = verdict_code;
    verdict_word.beacon_channel = verdict_ch;
    verdict_word.channel_found  = verdict_found;
    verdict_word.last           = 1'b1;
  end

  assign wr0      = in_fire && (ssid_emit || verdict_emit);
  assign wr1      = in_fire && ssid_emit && verdict_emit;
  assign wr0_word = ssid_emit ? ssid_word : verdict_word;
  assign q_wp1    = q_wp_r + QPtrW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_channel_r    <= RST_SCAN_CHANNEL;
      nonbeacon_limit_r <= RST_NONBEACON_LIMIT;
      element_start_r   <= RST_ELEMENT_START;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_CHANNEL:    scan_channel_r    <= cfg_wdata[3:0];
        REG_NONBEACON_LIMIT: nonbeacon_limit_r <= cfg_wdata;
        REG_ELEMENT_START:   element_start_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      beacon_r     <= 1'b0;
      phase_r      <= PH_TAG;
      tag_r        <= 8'd0;
      remain_r     <= 8'd0;
      ssid_cnt_r   <= '0;
      ssid_ended_r <= 1'b0;
      found_ch_r   <= 8'd0;
      found_r      <= 1'b0;
      frame_cnt_r  <= 8'd0;
      scan_done_r  <= 1'b0;
    end else if (in_fire) begin
      byte_pos_r   <= byte_pos_nxt;
      beacon_r     <= beacon_nxt;
      phase_r      <= phase_nxt;
      tag_r        <= tag_nxt;
      remain_r     <= remain_nxt;
      ssid_cnt_r   <= ssid_cnt_nxt;
      ssid_ended_r <= ssid_ended_nxt;
      found_ch_r   <= found_ch_nxt;
      found_r      <= found_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
      scan_done_r  <= scan_done_nxt;
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wp_r  <= q_wp_r + QPtrW'({1'b0, wr0} + {1'b0, wr1});
      if (out_fire)
        q_rp_r <= q_rp_r + QPtrW'(1);
      q_cnt_r <= q_cnt_r + QCntW'(wr0) + QCntW'(wr1) - QCntW'(out_fire);
    end
  end

  // Queue storage (payload, no reset)
  always_ff @(posedge clk) begin
    if (wr0)
      q_mem_r[q_wp_r] <= wr0_word;
    if (wr1)
      q_mem_r[q_wp1] <= verdict_word;
  end

  assign out_tvalid = (q_cnt_r != '0);
  assign out_tuser  = q_mem_r[q_rp_r].kind;
  assign out_tlast  = q_mem_r[q_rp_r].last;
  assign out_tdata  = {5'd0,
                       q_mem_r[q_rp_r].channel_found,
                       q_mem_r[q_rp_r].beacon_channel,
                       q_mem_r[q_rp_r].verdict,
                       q_mem_r[q_rp_r].ssid_char};

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCntW'(QDepth))
    else $error("output queue overflow");

  a_ssid_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ssid_cnt_r <= SsidW'(SSID_MAX))
    else $error("ssid count past cap");

  a_found_in_beacon: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> beacon_r)
    else $error("channel captured outside a beacon");

  a_timeout_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == CMD_TIMEOUT && !scan_done_r) |=> scan_done_r)
    else $error("timeout did not end the scan");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && scan_done_r && in_tuser != CMD_START) |=> $stable(q_wp_r))
    else $error("result after scan done");

endmodule

`default_nettype wire
